// ===== hdl/bbpc_pkg.sv =====
// Shared types and constants for the two-beam people counter.
`default_nettype none

package bbpc_pkg;

	// Field widths
	localparam int DIST_W  = 16;
	localparam int TIME_W  = 32;
	localparam int OCC_W   = 16;
	localparam int EVENT_W = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OOR_CODE   = 8'd3;

	// Configuration reset values
	localparam logic [DIST_W-1:0] THRESHOLD_RST = 16'd500;
	localparam logic [TIME_W-1:0] TIMEOUT_RST   = 32'd3000;
	localparam logic [TIME_W-1:0] HEARTBEAT_RST = 32'd60000;
	localparam logic [DIST_W-1:0] OOR_CODE_RST  = 16'd8190;

	// Pass tracker state codes
	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_A_FIRST = 2'd1;
	localparam logic [1:0] ST_B_FIRST = 2'd2;

	// Event codes
	localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
	localparam logic [EVENT_W-1:0] EV_ENTRY = 2'd1;
	localparam logic [EVENT_W-1:0] EV_EXIT  = 2'd2;

	typedef logic [DIST_W-1:0]  dist_t;
	typedef logic [TIME_W-1:0]  time_t;
	typedef logic [OCC_W-1:0]   occ_t;
	typedef logic [EVENT_W-1:0] event_t;

endpackage

`default_nettype wire

// ===== hdl/bbpc_if.sv =====
// Valid/ready channel interfaces for samples, results and register writes.
`default_nettype none

interface bbpc_sample_if import bbpc_pkg::*; ();
	logic  valid;
	logic  ready;
	dist_t dist_a;
	dist_t dist_b;
	time_t now_ms;

	modport source (output valid, dist_a, dist_b, now_ms, input ready);
	modport sink   (input valid, dist_a, dist_b, now_ms, output ready);
endinterface

interface bbpc_result_if import bbpc_pkg::*; ();
	logic   valid;
	logic   ready;
	occ_t   occupancy;
	event_t event_res;
	logic   report;

	modport source (output valid, occupancy, event_res, report, input ready);
	modport sink   (input valid, occupancy, event_res, report, output ready);
endinterface

interface bbpc_cfg_if import bbpc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, reg_index, data, input ready);
	modport sink   (input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/bidirectional_beam_people_counter_core.sv =====
// A sample passes through the input register, then the result register, before its result is valid.
// Throughput: one item per cycle while results are taken; the next tracker state and count are combinational.
// The result register lets a new sample enter while a finished result waits.
// Reset (arst_n low, asynchronous): pass tracker idle, count zero, first result reports,
// configuration registers return to their defaults; cfg writes are always accepted.
`default_nettype none

module bidirectional_beam_people_counter_core import bbpc_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	bbpc_cfg_if.sink     cfg,
	bbpc_sample_if.sink  sample,
	bbpc_result_if.source result
);

	typedef logic [COUNT_BITS-1:0] count_t;

	// Configuration registers
	dist_t threshold_q;
	time_t timeout_q;
	time_t heartbeat_q;
	dist_t oor_code_q;

	// Input stage
	logic  valid_s1;
	dist_t dist_a_s1;
	dist_t dist_b_s1;
	time_t now_s1;

	// Tracker state
	logic [1:0] pass_state_q;
	time_t      pass_start_q;
	count_t     count_q;
	occ_t       last_count_q;
	logic       never_reported_q;
	time_t      last_report_time_q;

	// Result register
	logic   res_valid_q;
	occ_t   res_occ_q;
	event_t res_event_q;
	logic   res_report_q;

	// Next-state values
	logic       blocked_a, blocked_b, timed_out, heartbeat_due;
	logic [1:0] pass_state_d;
	time_t      pass_start_d;
	count_t     count_d;
	event_t     event_d;
	occ_t       occ_d;
	logic       report_d;
	logic       advance;

	assign cfg.ready = 1'b1;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			timeout_q   <= TIMEOUT_RST;
			heartbeat_q <= HEARTBEAT_RST;
			oor_code_q  <= OOR_CODE_RST;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				REG_THRESHOLD: threshold_q <= cfg.data[DIST_W-1:0];
				REG_TIMEOUT:   timeout_q   <= cfg.data[TIME_W-1:0];
				REG_HEARTBEAT: heartbeat_q <= cfg.data[TIME_W-1:0];
				REG_OOR_CODE:  oor_code_q  <= cfg.data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the input stage moves on when the result register is free
	assign advance      = valid_s1 && (!res_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			dist_a_s1 <= sample.dist_a;
			dist_b_s1 <= sample.dist_b;
			now_s1    <= sample.now_ms;
		end
	end

	// Beam detection and time checks
	assign blocked_a     = (dist_a_s1 < threshold_q) && (dist_a_s1 != oor_code_q);
	assign blocked_b     = (dist_b_s1 < threshold_q) && (dist_b_s1 != oor_code_q);
	assign timed_out     = (now_s1 - pass_start_q) > timeout_q;
	assign heartbeat_due = (now_s1 - last_report_time_q) >= heartbeat_q;

	// Pass tracker; the other beam wins over the timeout
	always_comb begin
		pass_state_d = ST_IDLE;
		pass_start_d = pass_start_q;
		count_d      = count_q;
		event_d      = EV_NONE;
		case (pass_state_q)
			ST_A_FIRST: begin
				if (blocked_b) begin
					if (count_q != '1) count_d = count_q + 1'b1;
					event_d = EV_ENTRY;
				end else if (!timed_out) begin
					pass_state_d = ST_A_FIRST;
				end
			end
			ST_B_FIRST: begin
				if (blocked_a) begin
					if (count_q != '0) count_d = count_q - 1'b1;
					event_d = EV_EXIT;
				end else if (!timed_out) begin
					pass_state_d = ST_B_FIRST;
				end
			end
			default: begin
				if (blocked_a && !blocked_b) begin
					pass_state_d = ST_A_FIRST;
					pass_start_d = now_s1;
				end else if (blocked_b && !blocked_a) begin
					pass_state_d = ST_B_FIRST;
					pass_start_d = now_s1;
				end
			end
		endcase
		occ_d    = OCC_W'(count_d);
		report_d = never_reported_q || (occ_d != last_count_q) || heartbeat_due;
	end

	// State update as the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_state_q       <= ST_IDLE;
			pass_start_q       <= '0;
			count_q            <= '0;
			last_count_q       <= '0;
			never_reported_q   <= 1'b1;
			last_report_time_q <= '0;
		end else if (advance) begin
			pass_state_q <= pass_state_d;
			pass_start_q <= pass_start_d;
			count_q      <= count_d;
			if (report_d) begin
				last_count_q       <= occ_d;
				last_report_time_q <= now_s1;
				never_reported_q   <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_occ_q    <= occ_d;
			res_event_q  <= event_d;
			res_report_q <= report_d;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.occupancy = res_occ_q;
	assign result.event_res = res_event_q;
	assign result.report    = res_report_q;

endmodule

`default_nettype wire

// ===== hdl/bbpc_checker.sv =====
// Port-level checks for the people counter, bound to the counter core.
`default_nettype none

module bbpc_port_checks import bbpc_pkg::*; (
	input wire    clk,
	input wire    arst_n,
	input wire    res_valid,
	input wire    res_ready,
	input occ_t   res_occupancy,
	input event_t res_event,
	input wire    res_report
);

	logic seen_q;
	occ_t prev_occ_q;
	logic res_accept;

	assign res_accept = res_valid && res_ready;

	// Track the first delivered item and the last delivered count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (res_accept) begin
			seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_accept) prev_occ_q <= res_occupancy;
	end

	// No result during reset
	a_no_result_in_reset: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	// A stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=>
			res_valid && $stable(res_occupancy) && $stable(res_event) && $stable(res_report))
		else $error("stalled result changed");

	// First result after reset always reports
	a_first_reports: assert property (@(posedge clk) disable iff (!arst_n)
		res_accept && !seen_q |-> res_report)
		else $error("first result without report");

	// A changed count is always reported
	a_change_reports: assert property (@(posedge clk) disable iff (!arst_n)
		res_accept && seen_q && (res_occupancy != prev_occ_q) |-> res_report)
		else $error("count changed without report");

	// Without an event the count does not move
	a_count_steady: assert property (@(posedge clk) disable iff (!arst_n)
		res_accept && seen_q && (res_event == EV_NONE) |-> res_occupancy == prev_occ_q)
		else $error("count moved without an event");

endmodule

bind bidirectional_beam_people_counter_core bbpc_port_checks u_bbpc_port_checks (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.res_occupancy (result.occupancy),
	.res_event     (result.event_res),
	.res_report    (result.report)
);

`default_nettype wire
